>>> design/iouba_pkg.sv
// ----------------------------------------------------------------------------
// iouba_pkg
// Shared types and constants for the IoU box association block.
// ----------------------------------------------------------------------------
`default_nettype none

package iouba_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int COORD_W         = 12;
  localparam int ID_W            = 16;
  localparam int THR_W           = 16;
  localparam int MODE_W          = 2;
  localparam int IDX_OUT_W       = 5;
  localparam int AREA_W          = 2 * COORD_W;
  localparam int UNI_W           = AREA_W + 1;
  localparam int PROD_W          = 2 * UNI_W;
  localparam int IN_DATA_W       = 64;   // 4 coords + id, already whole bytes
  localparam int OUT_DATA_W      = 24;   // id + index, padded to bytes
  localparam int OUT_USER_W      = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MATCH = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [AREA_W-1:0]  area;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_MUL,
    ST_LD_WR,
    ST_AREA_MUL,
    ST_AREA_SAV,
    ST_RD,
    ST_OVL,
    ST_INTER,
    ST_UNION,
    ST_THR_MUL,
    ST_THR_CMP,
    ST_BEST_MUL1,
    ST_BEST_MUL2,
    ST_BEST_CMP,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> design/iouba_mul.sv
// ----------------------------------------------------------------------------
// iouba_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module iouba_mul (
  input  wire logic                         clk,
  input  wire logic [iouba_pkg::UNI_W-1:0]  mul_a,
  input  wire logic [iouba_pkg::UNI_W-1:0]  mul_b,
  output logic      [iouba_pkg::PROD_W-1:0] prod_r
);
  import iouba_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

`default_nettype wire

>>> design/iouba_table.sv
// ----------------------------------------------------------------------------
// iouba_table
// Previous-frame box table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module iouba_table #(
  parameter  int DEPTH = iouba_pkg::DEF_TABLE_DEPTH,
  localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IdxW-1:0]       wr_addr,
  input  wire iouba_pkg::box_entry_t wr_data,
  input  wire logic [IdxW-1:0]       rd_addr,
  output iouba_pkg::box_entry_t      rd_data_r
);
  import iouba_pkg::*;

  box_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/iou_box_association.sv
// Clear, mode 3 and table-full loads end in idle; a load multiplies the area
// and writes. A match multiplies the area, then per box reads, overlaps,
// multiplies and thresholds, cross-multiplying a passing pair once a best is
// held; one multiplier serves every product; done waits on a held result.
// Sync active-low reset clears the table count, track counter, threshold
// and output valid; the table contents are not cleared.
// ----------------------------------------------------------------------------
// iou_box_association
// Greedy IoU track association over a table of previous-frame boxes.
// ----------------------------------------------------------------------------
`default_nettype none

module iou_box_association #(
  parameter int TABLE_DEPTH = iouba_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // tdata: box_left[11:0], box_top[23:12], box_width[35:24],
  //        box_height[47:36], track_id_in[63:48]
  input  wire logic [iouba_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: mode[1:0]
  input  wire logic [iouba_pkg::MODE_W-1:0]     in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tdata: track_id_out[15:0], matched_index[20:16], zero pad[23:21]
  output logic      [iouba_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: is_new_track[0], id_overflow[1]
  output logic      [iouba_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [iouba_pkg::THR_W-1:0]      cfg_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);
  import iouba_pkg::*;

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(TABLE_DEPTH);
  localparam logic [ID_W-1:0] IdMax  = '1;

  function automatic logic [COORD_W-1:0] overlap_1d(
    input logic [COORD_W-1:0] s1, input logic [COORD_W-1:0] len1,
    input logic [COORD_W-1:0] s2, input logic [COORD_W-1:0] len2);
    logic [COORD_W:0] lo, hi, e1, e2, d;
    lo = (s1 > s2) ? {1'b0, s1} : {1'b0, s2};
    e1 = {1'b0, s1} + {1'b0, len1};
    e2 = {1'b0, s2} + {1'b0, len2};
    hi = (e1 < e2) ? e1 : e2;
    d  = hi - lo;
    return (hi > lo) ? d[COORD_W-1:0] : '0;
  endfunction

  // control state
  state_t            state_r, state_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [ID_W-1:0]   ctr_r, ctr_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath
  logic [COORD_W-1:0] bl_r, bl_nxt, bt_r, bt_nxt, bw_r, bw_nxt, bh_r, bh_nxt;
  logic [ID_W-1:0]    bid_r, bid_nxt;
  logic [AREA_W-1:0]  area_n_r, area_n_nxt;
  logic [CntW-1:0]    idx_r, idx_nxt;
  logic [COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [AREA_W-1:0]  inter_r, inter_nxt;
  logic [UNI_W-1:0]   uni_r, uni_nxt;
  logic               found_r, found_nxt;
  logic [AREA_W-1:0]  best_inter_r, best_inter_nxt;
  logic [UNI_W-1:0]   best_union_r, best_union_nxt;
  logic [IdxW-1:0]    best_idx_r, best_idx_nxt;
  logic [ID_W-1:0]    best_id_r, best_id_nxt;
  logic [PROD_W-1:0]  p1_r, p1_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic [UNI_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;
  logic              wr_en;
  box_entry_t        wr_data, rd_data_r;
  logic              in_xfer;
  logic [CntW-1:0]   idx_inc;
  logic [PROD_W-1:0] inter_sh;
  logic              take_best;

  iouba_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  iouba_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (count_r[IdxW-1:0]),
    .wr_data   (wr_data),
    .rd_addr   (idx_r[IdxW-1:0]),
    .rd_data_r (rd_data_r)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign idx_inc    = idx_r + CntW'(1);
  assign inter_sh   = PROD_W'({inter_r, 16'h0000});

  always_comb begin
    wr_data.id     = bid_r;
    wr_data.area   = prod_r[AREA_W-1:0];
    wr_data.height = bh_r;
    wr_data.width  = bw_r;
    wr_data.top    = bt_r;
    wr_data.left   = bl_r;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ctr_nxt        = ctr_r;
    thr_nxt        = cfg_valid ? cfg_data : thr_r;
    out_valid_nxt  = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    bl_nxt         = bl_r;
    bt_nxt         = bt_r;
    bw_nxt         = bw_r;
    bh_nxt         = bh_r;
    bid_nxt        = bid_r;
    area_n_nxt     = area_n_r;
    idx_nxt        = idx_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    inter_nxt      = inter_r;
    uni_nxt        = uni_r;
    found_nxt      = found_r;
    best_inter_nxt = best_inter_r;
    best_union_nxt = best_union_r;
    best_idx_nxt   = best_idx_r;
    best_id_nxt    = best_id_r;
    p1_nxt         = p1_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    mul_a          = UNI_W'(bw_r);
    mul_b          = UNI_W'(bh_r);
    wr_en          = 1'b0;
    take_best      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          bl_nxt   = in_tdata[11:0];
          bt_nxt   = in_tdata[23:12];
          bw_nxt   = in_tdata[35:24];
          bh_nxt   = in_tdata[47:36];
          bid_nxt  = in_tdata[63:48];
          case (in_tuser)
            MODE_CLEAR: count_nxt = '0;
            MODE_LOAD:  if (count_r < CntMax) state_nxt = ST_LD_MUL;
            MODE_MATCH: state_nxt = ST_AREA_MUL;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_MUL: state_nxt = ST_LD_WR;
      ST_LD_WR: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CntW'(1);
        state_nxt = ST_IDLE;
      end
      ST_AREA_MUL: state_nxt = ST_AREA_SAV;
      ST_AREA_SAV: begin
        area_n_nxt     = prod_r[AREA_W-1:0];
        idx_nxt        = '0;
        found_nxt      = 1'b0;
        best_inter_nxt = '0;
        best_union_nxt = UNI_W'(1);
        best_idx_nxt   = '0;
        state_nxt      = (count_r == '0) ? ST_DONE : ST_RD;
      end
      ST_RD: state_nxt = ST_OVL;  // table read lands in rd_data_r
      ST_OVL: begin
        ox_nxt    = overlap_1d(rd_data_r.left, rd_data_r.width, bl_r, bw_r);
        oy_nxt    = overlap_1d(rd_data_r.top, rd_data_r.height, bt_r, bh_r);
        state_nxt = ST_INTER;
      end
      ST_INTER: begin
        mul_a     = UNI_W'(ox_r);
        mul_b     = UNI_W'(oy_r);
        state_nxt = ST_UNION;
      end
      ST_UNION: begin
        inter_nxt = prod_r[AREA_W-1:0];
        uni_nxt   = {1'b0, rd_data_r.area} + {1'b0, area_n_r}
                    - {1'b0, prod_r[AREA_W-1:0]};
        state_nxt = ST_THR_MUL;
      end
      ST_THR_MUL: begin
        mul_a     = UNI_W'(thr_r);
        mul_b     = uni_r;
        state_nxt = (uni_r == '0) ? ST_NEXT : ST_THR_CMP;
      end
      ST_THR_CMP: begin
        // inter/union > thr/65536
        if (inter_sh > prod_r) begin
          if (!found_r) begin
            take_best = 1'b1;
            state_nxt = ST_NEXT;
          end else begin
            state_nxt = ST_BEST_MUL1;
          end
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_BEST_MUL1: begin
        mul_a     = UNI_W'(inter_r);
        mul_b     = best_union_r;
        state_nxt = ST_BEST_MUL2;
      end
      ST_BEST_MUL2: begin
        p1_nxt    = prod_r;
        mul_a     = UNI_W'(best_inter_r);
        mul_b     = uni_r;
        state_nxt = ST_BEST_CMP;
      end
      ST_BEST_CMP: begin
        take_best = (p1_r > prod_r);
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (idx_inc < count_r) begin
          idx_nxt   = idx_inc;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_data_nxt = OUT_DATA_W'({IDX_OUT_W'(best_idx_r), best_id_r});
            out_user_nxt = 2'b00;
          end else if (ctr_r != IdMax) begin
            ctr_nxt      = ctr_r + ID_W'(1);
            out_data_nxt = OUT_DATA_W'({IDX_OUT_W'(0), ctr_nxt});
            out_user_nxt = 2'b01;
          end else begin
            out_data_nxt = OUT_DATA_W'({IDX_OUT_W'(0), IdMax});
            out_user_nxt = 2'b11;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (take_best) begin
      found_nxt      = 1'b1;
      best_inter_nxt = inter_r;
      best_union_nxt = uni_r;
      best_idx_nxt   = idx_r[IdxW-1:0];
      best_id_nxt    = rd_data_r.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ctr_r       <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ctr_r       <= ctr_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bl_r         <= bl_nxt;
    bt_r         <= bt_nxt;
    bw_r         <= bw_nxt;
    bh_r         <= bh_nxt;
    bid_r        <= bid_nxt;
    area_n_r     <= area_n_nxt;
    idx_r        <= idx_nxt;
    ox_r         <= ox_nxt;
    oy_r         <= oy_nxt;
    inter_r      <= inter_nxt;
    uni_r        <= uni_nxt;
    found_r      <= found_nxt;
    best_inter_r <= best_inter_nxt;
    best_union_r <= best_union_nxt;
    best_idx_r   <= best_idx_nxt;
    best_id_r    <= best_id_nxt;
    p1_r         <= p1_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

endmodule

`default_nettype wire

>>> dv/tb_iou_box_association.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iou_box_association
// Self-checking bench for the IoU box association block. A directed table
// hits reset values, extreme boxes, ties, zero areas and clears. Random
// frames of clear/load/match then run under several overlap thresholds.
// Each result is checked against a typed directed row or the association model.
// ----------------------------------------------------------------------------

module tb_iou_box_association;
  import iouba_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;  // unused code, ignored
  localparam int TAB_DEPTH     = DEF_TABLE_DEPTH;
  localparam int SETTLE_CYCLES = 400;      // > worst match walk of a full table
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 200;
  localparam int NUM_PHASES    = 7;
  localparam int DIR_N         = 22;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef bit [63:0] wide_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic                 new_trk;
    logic [IDX_OUT_W-1:0] idx;
    logic                 ovf;
  } assoc_result_t;

  typedef struct {
    logic [COORD_W-1:0] l, t, w, h;
    logic [ID_W-1:0]    id;
  } prev_box_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] l, t, w, h;
    logic [ID_W-1:0]    id;
    bit                 typed;
    assoc_result_t      res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [THR_W-1:0]      cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  iou_box_association dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // association model state
  prev_box_t        prev_tab [TAB_DEPTH];
  int               prev_cnt = 0;
  logic [ID_W-1:0]  trk_cnt = '0;
  logic [THR_W-1:0] thr_q = '0;

  assoc_result_t exp_q [$];

  int     err_cnt = 0;
  int     n_items = 0, n_results = 0, n_matched = 0, n_new = 0, n_ovf = 0;
  int     n_cfg = 0;
  longint cyc = 0;
  bit     quiet = 1'b0;     // no idling on either side
  bit     burst_on = 1'b1;
  bit     hold_req = 1'b0;

  dir_row_t dir_tab [DIR_N] = '{
    '{MODE_MATCH, 12'd10,   12'd10,   12'd20,   12'd20,   16'h0000, 1'b1,
      '{16'd1, 1'b1, 5'd0, 1'b0}},
    '{MODE_NONE,  12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  16'hFFFF, 1'b0, '0},
    '{MODE_LOAD,  12'd0,    12'd0,    12'hFFF,  12'hFFF,  16'hFFFF, 1'b0, '0},
    '{MODE_LOAD,  12'd100,  12'd100,  12'd50,   12'd50,   16'h0000, 1'b0, '0},
    '{MODE_LOAD,  12'hFFF,  12'hFFF,  12'd0,    12'd0,    16'h0007, 1'b0, '0},
    '{MODE_MATCH, 12'd0,    12'd0,    12'hFFF,  12'hFFF,  16'h0000, 1'b1,
      '{16'hFFFF, 1'b0, 5'd0, 1'b0}},
    '{MODE_MATCH, 12'd100,  12'd100,  12'd50,   12'd50,   16'h0000, 1'b1,
      '{16'h0000, 1'b0, 5'd1, 1'b0}},
    '{MODE_MATCH, 12'hFFF,  12'hFFF,  12'd0,    12'd0,    16'h0000, 1'b1,
      '{16'd2, 1'b1, 5'd0, 1'b0}},
    // touches the second box on its right edge, overlaps the big one
    '{MODE_MATCH, 12'd150,  12'd100,  12'd50,   12'd50,   16'h0000, 1'b0, '0},
    '{MODE_MATCH, 12'd0,    12'd0,    12'd0,    12'd0,    16'h0000, 1'b1,
      '{16'd3, 1'b1, 5'd0, 1'b0}},
    '{MODE_CLEAR, 12'd0,    12'd0,    12'd0,    12'd0,    16'h0000, 1'b0, '0},
    '{MODE_MATCH, 12'd10,   12'd10,   12'd20,   12'd20,   16'h0000, 1'b1,
      '{16'd4, 1'b1, 5'd0, 1'b0}},
    '{MODE_LOAD,  12'd200,  12'd200,  12'd40,   12'd40,   16'h0005, 1'b0, '0},
    '{MODE_LOAD,  12'd200,  12'd200,  12'd40,   12'd40,   16'h0006, 1'b0, '0},
    '{MODE_LOAD,  12'd205,  12'd200,  12'd40,   12'd40,   16'h0009, 1'b0, '0},
    // tie on equal IoU: first entry wins
    '{MODE_MATCH, 12'd200,  12'd200,  12'd40,   12'd40,   16'h0000, 1'b1,
      '{16'h0005, 1'b0, 5'd0, 1'b0}},
    '{MODE_MATCH, 12'd205,  12'd200,  12'd40,   12'd40,   16'h0000, 1'b1,
      '{16'h0009, 1'b0, 5'd2, 1'b0}},
    '{MODE_LOAD,  12'd4000, 12'd4000, 12'hFFF,  12'hFFF,  16'h1234, 1'b0, '0},
    '{MODE_MATCH, 12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  16'h0000, 1'b0, '0},
    '{MODE_NONE,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000, 1'b0, '0},
    '{MODE_CLEAR, 12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  16'hFFFF, 1'b0, '0},
    '{MODE_MATCH, 12'd0,    12'd0,    12'hFFF,  12'hFFF,  16'h0000, 1'b1,
      '{16'd5, 1'b1, 5'd0, 1'b0}}
  };

  function automatic logic [IN_DATA_W-1:0] pack_box(
      logic [COORD_W-1:0] l, logic [COORD_W-1:0] t, logic [COORD_W-1:0] w,
      logic [COORD_W-1:0] h, logic [ID_W-1:0] id);
    return {id, h, w, t, l};
  endfunction

  function automatic wide_t span_overlap(wide_t s1, wide_t n1, wide_t s2, wide_t n2);
    wide_t lo, hi;
    lo = (s1 > s2) ? s1 : s2;
    hi = (s1 + n1 < s2 + n2) ? s1 + n1 : s2 + n2;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  // Advances the association state for one accepted item.
  task automatic associate(input logic [MODE_W-1:0] mode,
                           input logic [IN_DATA_W-1:0] data,
                           output bit has_res, output assoc_result_t r,
                           output bit ignored);
    wide_t l, t, w, h, area, inter, uni, best_inter, best_uni;
    int    best_idx;
    bit    found;
    l = data[11:0];
    t = data[23:12];
    w = data[35:24];
    h = data[47:36];
    has_res = 1'b0;
    ignored = 1'b0;
    r = '0;
    found = 1'b0;
    best_idx = 0;
    best_inter = 0;
    best_uni = 1;
    case (mode)
      MODE_CLEAR: prev_cnt = 0;
      MODE_LOAD: begin
        if (prev_cnt < TAB_DEPTH) begin
          prev_tab[prev_cnt] = '{data[11:0], data[23:12], data[35:24], data[47:36],
                                 data[63:48]};
          prev_cnt++;
        end else begin
          ignored = 1'b1;
        end
      end
      MODE_MATCH: begin
        area = w * h;
        for (int i = 0; i < prev_cnt; i++) begin
          inter = span_overlap(prev_tab[i].l, prev_tab[i].w, l, w) *
                  span_overlap(prev_tab[i].t, prev_tab[i].h, t, h);
          uni = wide_t'(prev_tab[i].w) * wide_t'(prev_tab[i].h) + area - inter;
          if (uni != 0 && inter * 65536 > wide_t'(thr_q) * uni) begin
            if (!found || inter * best_uni > best_inter * uni) begin
              found = 1'b1;
              best_inter = inter;
              best_uni = uni;
              best_idx = i;
            end
          end
        end
        has_res = 1'b1;
        if (found) begin
          r = '{prev_tab[best_idx].id, 1'b0, IDX_OUT_W'(best_idx), 1'b0};
        end else begin
          if (trk_cnt != '1) trk_cnt++;
          else r.ovf = 1'b1;
          r.id = trk_cnt;
          r.new_trk = 1'b1;
        end
      end
      default: ignored = 1'b1;
    endcase
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IN_DATA_W-1:0] data);
    bit            has_res, ignored;
    assoc_result_t r;
    in_tuser  <= mode;
    in_tdata  <= data;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    associate(mode, data, has_res, r, ignored);
    if (has_res) exp_q.insert(exp_q.size(), r);
    if (!ignored) n_items++;
  endtask

  task automatic sender_gap();
    if (!quiet && burst_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Only while idle: all results in and a match walk's worth of cycles gone.
  task automatic set_threshold(input logic [THR_W-1:0] v);
    in_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_q = v;
    n_cfg++;
  endtask

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] edge_coord();
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_load_box();
    int k;
    logic [ID_W-1:0] id;
    k  = $urandom_range(0, 99);
    id = ($urandom_range(0, 29) == 0) ? '0 : ID_W'($urandom);
    if (k < 10)
      return pack_box(edge_coord(), edge_coord(), edge_coord(), edge_coord(), id);
    if (k < 18)
      return pack_box(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom_range(0, 1)),
                      COORD_W'($urandom_range(0, 40)), id);
    if (k < 45)
      return pack_box(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), id);
    return pack_box(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom_range(1, 300)),
                    COORD_W'($urandom_range(1, 300)), id);
  endfunction

  // Mostly boxes near a stored one, so the threshold and best-pick paths run.
  function automatic logic [IN_DATA_W-1:0] rand_match_box();
    int        k, d;
    prev_box_t e;
    logic [ID_W-1:0] junk;
    junk = ID_W'($urandom);
    k = $urandom_range(0, 99);
    if (prev_cnt == 0 || k < 12)
      return pack_box(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), junk);
    e = prev_tab[$urandom_range(0, prev_cnt - 1)];
    d = $urandom_range(1, 40);
    if (k < 22) return pack_box(e.l, e.t, e.w, e.h, junk);
    if (k < 30)
      return pack_box(clamp_coord(int'(e.l) + int'(e.w)), e.t, e.w, e.h, junk);
    if (k < 37) return pack_box(e.l, e.t, '0, e.h, junk);
    if (k < 42)
      return pack_box(edge_coord(), edge_coord(), edge_coord(), edge_coord(), junk);
    return pack_box(clamp_coord(int'(e.l) + $urandom_range(0, 2 * d) - d),
                    clamp_coord(int'(e.t) + $urandom_range(0, 2 * d) - d),
                    clamp_coord(int'(e.w) + $urandom_range(0, 2 * d) - d),
                    clamp_coord(int'(e.h) + $urandom_range(0, 2 * d) - d), junk);
  endfunction

  task automatic run_frame(input bit fill_table);
    int k, nloads, nmatches;
    burst_on = ($urandom_range(0, 9) < 7);
    if (fill_table || $urandom_range(0, 99) < 85) begin
      send_item(MODE_CLEAR, {$urandom, $urandom});
      sender_gap();
    end
    k = $urandom_range(0, 99);
    if (fill_table)   nloads = 34;
    else if (k < 6)   nloads = 0;
    else if (k < 80)  nloads = $urandom_range(1, 8);
    else if (k < 93)  nloads = $urandom_range(9, 31);
    else              nloads = $urandom_range(32, 36);
    for (int i = 0; i < nloads; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(MODE_NONE, {$urandom, $urandom});
      send_item(MODE_LOAD, rand_load_box());
      sender_gap();
    end
    nmatches = $urandom_range(0, 10);
    for (int i = 0; i < nmatches; i++) begin
      send_item(MODE_MATCH, rand_match_box());
      sender_gap();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    assoc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected result, expected none, actual id %0d", $time,
                 out_tdata[15:0]);
      end else begin
        want = exp_q.pop_front();
        n_results++;
        if (want.new_trk) n_new++;
        else n_matched++;
        if (want.ovf) n_ovf++;
        check_field("track_id_out", want.id, out_tdata[15:0]);
        check_field("matched_index", want.idx, out_tdata[20:16]);
        check_field("is_new_track", want.new_trk, out_tuser[0]);
        check_field("id_overflow", want.ovf, out_tuser[1]);
      end
    end
  end

  // receiver: random ready bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [THR_W-1:0] thr_plan [NUM_PHASES];
    int               start;
    thr_plan = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0001, 16'h0000, 16'h4000};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, threshold still at its reset value
    for (int r = 0; r < DIR_N; r++) begin
      send_item(dir_tab[r].mode, pack_box(dir_tab[r].l, dir_tab[r].t, dir_tab[r].w,
                                          dir_tab[r].h, dir_tab[r].id));
      if (dir_tab[r].typed) exp_q[exp_q.size() - 1] = dir_tab[r].res;
      sender_gap();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_threshold((p == 3 || p == 5) ? THR_W'($urandom) : thr_plan[p]);
      if (p == 2) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      start = n_items;
      run_frame(p == 0);
      while (n_items - start < PHASE_ITEMS) run_frame(1'b0);
    end
    in_tvalid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items, %0d results (%0d matched, %0d new, %0d at counter limit),",
             n_items, n_results, n_matched, n_new, n_ovf);
    $display("over %0d threshold writes and one long output stall; %0d mismatches.",
             n_cfg, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
